@@ design/i2a_pkg.sv @@
// Package for the integer to ASCII converter.
// It holds the request and result types, the sequencer states, the sizes and the character codes.
// It depends on nothing else.
`default_nettype none

package i2a_pkg;

    // Sizes of the binary value and of the decimal digit store.
    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;
    localparam int HEX_DIGITS = VALUE_W / 4;
    localparam int DIGITS_W   = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    // Mode codes. Bit 1 alone selects hexadecimal.
    localparam logic [1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [1:0] MODE_SIGNED   = 2'd1;
    localparam int         MODE_HEX_BIT  = 1;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_ALPHA_BASE = 8'h37;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_SUFFIX_H   = 8'h48;

    // One request: the value and its mode.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         mode;
    } in_t;

    // One result: a character and the flag on the final one.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } out_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT,
        ST_SUFFIX
    } state_t;

    // Maps one digit to its upper-case ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] d_ext;
        d_ext = {4'h0, d};
        if (d < 4'd10)
        begin
            return CHAR_ZERO + d_ext;
        end
        return CHAR_ALPHA_BASE + d_ext;
    endfunction

endpackage

`default_nettype wire

@@ design/i2a_dabble.sv @@
// Iterative binary to BCD unit using the shift-and-add-3 method, one bit per cycle.
// It depends on i2a_pkg for the value and digit store widths.
`default_nettype none

module i2a_dabble
    import i2a_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [VALUE_W-1:0]  value,
    output logic                     busy,
    output logic [DIGITS_W-1:0]      bcd
);

    logic                 busy_reg, busy_next;
    logic [BIT_CNT_W-1:0] count_reg, count_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [DIGITS_W-1:0]  bcd_reg, bcd_next;
    logic [DIGITS_W-1:0]  bcd_adj;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Load on start, otherwise shift one binary bit into the digit store per cycle while busy.
    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = BIT_CNT_W'(VALUE_W - 1);
            bin_next   = value;
            bcd_next   = '0;
        end
        else if (busy_reg)
        begin
            bin_next   = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next   = {bcd_adj[DIGITS_W-2:0], bin_reg[VALUE_W-1]};
            count_next = count_reg - BIT_CNT_W'(1);
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = busy_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

@@ design/integer_to_ascii_converter.sv @@
// Top level of the integer to ASCII converter: sequencer, digit store and output register.
// It depends on i2a_pkg and instantiates i2a_dabble.
`default_nettype none

// Each request carries a 64-bit value and a mode (unsigned decimal, signed decimal, or
// hexadecimal with an 'H' suffix; mode 3 acts as hexadecimal), and the block answers with
// the ASCII text of the value, one character per result, most significant first, with last
// set on the final character. There are no leading zeros, and zero gives "0" (or "0H").
// The block takes one request at a time and is not ready while it works on it. A decimal
// request is accepted, then waits in the convert state on the bit-serial BCD unit (the
// shifts and the load of the digits), then drops leading zero digits in the skip state and
// finds the first digit there, then sends a minus sign if negative and then the digits. A
// hexadecimal request skips the BCD unit: after acceptance it goes straight to the skip
// state, then sends the digits and the suffix. A stalled result consumer holds up the
// sign, digit and suffix states.
module integer_to_ascii_converter
    import i2a_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic arg_valid,
    output logic      arg_ready,
    input  wire in_t  arg,
    output logic      text_valid,
    input  wire logic text_ready,
    output out_t      text
);

    state_t              state_reg, state_next;
    logic [DIGITS_W-1:0] digits_reg, digits_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic                neg_reg, neg_next;
    logic                hex_reg, hex_next;
    logic                text_valid_reg, text_valid_next;
    out_t                text_reg, text_next;

    logic                accept;
    logic                arg_hex;
    logic                arg_neg;
    logic [VALUE_W-1:0]  magnitude;
    logic                load_ok;
    logic                dab_busy;
    logic [DIGITS_W-1:0] dab_bcd;
    logic [3:0]          top_digit;

    assign accept  = arg_valid && arg_ready;
    assign arg_hex = arg.mode[MODE_HEX_BIT];
    assign arg_neg = (arg.mode == MODE_SIGNED) && arg.value[VALUE_W-1];

    // Two's complement magnitude of a negative signed request.
    assign magnitude = arg_neg ? (~arg.value + VALUE_W'(1)) : arg.value;

    // The output register can take a character when it is empty or being drained.
    assign load_ok   = !text_valid_reg || text_ready;
    assign top_digit = digits_reg[DIGITS_W-1 -: 4];

    // Bit-serial binary to BCD conversion of the magnitude.
    i2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && !arg_hex),
        .value (magnitude),
        .busy  (dab_busy),
        .bcd   (dab_bcd)
    );

    // Sequencer: next state, digit store and output register loads.
    always_comb
    begin
        state_next      = state_reg;
        digits_next     = digits_reg;
        left_next       = left_reg;
        neg_next        = neg_reg;
        hex_next        = hex_reg;
        text_next       = text_reg;
        text_valid_next = text_valid_reg && !text_ready;
        arg_ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (arg_valid)
                begin
                    hex_next = arg_hex;
                    neg_next = arg_neg;
                    if (arg_hex)
                    begin
                        digits_next = {arg.value, {(DIGITS_W - VALUE_W){1'b0}}};
                        left_next   = LEFT_W'(HEX_DIGITS);
                        state_next  = ST_SKIP;
                    end
                    else
                    begin
                        left_next  = LEFT_W'(NUM_DIGITS);
                        state_next = ST_CONVERT;
                    end
                end
            end
            ST_CONVERT:
            begin
                if (!dab_busy)
                begin
                    digits_next = dab_bcd;
                    state_next  = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zero digits, but always keep one digit.
                if ((left_reg != LEFT_W'(1)) && (top_digit == 4'd0))
                begin
                    digits_next = {digits_reg[DIGITS_W-5:0], 4'h0};
                    left_next   = left_reg - LEFT_W'(1);
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (load_ok)
                begin
                    text_next.character = CHAR_MINUS;
                    text_next.last      = 1'b0;
                    text_valid_next     = 1'b1;
                    state_next          = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    text_next.character = digit_char(top_digit);
                    text_next.last      = !hex_reg && (left_reg == LEFT_W'(1));
                    text_valid_next     = 1'b1;
                    digits_next         = {digits_reg[DIGITS_W-5:0], 4'h0};
                    left_next           = left_reg - LEFT_W'(1);
                    if (left_reg == LEFT_W'(1))
                    begin
                        state_next = hex_reg ? ST_SUFFIX : ST_IDLE;
                    end
                end
            end
            ST_SUFFIX:
            begin
                if (load_ok)
                begin
                    text_next.character = CHAR_SUFFIX_H;
                    text_next.last      = 1'b1;
                    text_valid_next     = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            text_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            text_valid_reg <= text_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        left_reg   <= left_next;
        neg_reg    <= neg_next;
        hex_reg    <= hex_next;
        text_reg   <= text_next;
    end

    assign text_valid = text_valid_reg;
    assign text       = text_reg;

    // The BCD unit is never busy while a new request can be accepted.
    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !dab_busy)
        else $error("BCD unit busy while the converter is idle");

    // A decimal request puts the sequencer in the convert state with the BCD unit busy in the next cycle.
    a_decimal_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !arg_hex) |=> (state_reg == ST_CONVERT) && dab_busy)
        else $error("decimal request did not start the BCD unit");

    // The digit count stays in range while digits are skipped or sent.
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SKIP) || (state_reg == ST_EMIT)) |->
        ((left_reg != '0) && (left_reg <= LEFT_W'(NUM_DIGITS))))
        else $error("digit count out of range");

    // A hexadecimal digit is never flagged as the final character.
    a_hex_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && hex_reg && load_ok) |=> !text_reg.last)
        else $error("hexadecimal digit flagged as last");

endmodule

`default_nettype wire

@@ sim/tb_integer_to_ascii_converter.sv @@
// Testbench for integer_to_ascii_converter: random and directed values in every mode,
// with the expected text predicted here and checked one character at a time.
// It depends on i2a_pkg and the design files of the converter.
`timescale 1ns / 100ps

module tb_integer_to_ascii_converter;
    import i2a_pkg::*;

    // Hexadecimal mode codes; mode three decodes like mode two.
    localparam logic [1:0] MODE_HEX      = 2'd2;
    localparam logic [1:0] MODE_HEX_ALT  = 2'd3;
    localparam logic [7:0] ASCII_UPPER_A = "A";
    localparam int RANDOM_COUNT  = 460;
    localparam int CALM_TAIL     = 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 40;

    // A queued request and whether the sender must let all text drain before it.
    typedef struct {
        in_t req;
        bit  wait_drain;
    } queued_req_t;

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic arg_valid  = 1'b0;
    logic text_ready = 1'b0;
    in_t  arg        = '0;
    logic arg_ready;
    logic text_valid;
    out_t text;

    queued_req_t request_queue[$];
    out_t        pending_chars[$];
    int          total_requests = 0;
    int          requests_taken = 0;
    int          chars_seen     = 0;
    int          error_count    = 0;
    int          send_gap       = 0;
    int          stall_left     = 0;
    int          quiet_cycles   = 0;

    integer_to_ascii_converter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .arg_valid  (arg_valid),
        .arg_ready  (arg_ready),
        .arg        (arg),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text)
    );

    always #5 clk = ~clk;

    // Appends the characters that one request must produce to the expected text.
    function automatic void predict_text(input in_t req);
        logic [7:0]  chars[$];
        logic [63:0] mag;
        logic [63:0] base;
        logic [63:0] digit;
        bit          is_hex;
        bit          negative;
        out_t        ch;
        is_hex   = req.mode[MODE_HEX_BIT];
        negative = !is_hex && req.mode == MODE_SIGNED && req.value[63];
        base     = is_hex ? 64'd16 : 64'd10;
        // Negation modulo 2^64 keeps the most negative value exact.
        mag      = negative ? 64'd0 - req.value : req.value;
        do
        begin
            digit = mag % base;
            if (digit < 10)
            begin
                chars.push_front(CHAR_ZERO + digit[7:0]);
            end
            else
            begin
                chars.push_front(ASCII_UPPER_A + digit[7:0] - 8'd10);
            end
            mag = mag / base;
        end
        while (mag != 0);
        if (negative)
        begin
            chars.push_front(CHAR_MINUS);
        end
        if (is_hex)
        begin
            chars.push_back(CHAR_SUFFIX_H);
        end
        foreach (chars[k])
        begin
            ch.character = chars[k];
            ch.last      = (k == chars.size() - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    // Picks a value with a spread of digit counts and the awkward corners.
    function automatic logic [63:0] random_value();
        logic [63:0] p;
        int          kind;
        kind = $urandom_range(0, 9);
        p    = 64'd1;
        case (kind)
            0: return 64'($urandom_range(0, 20));
            1:
            begin
                repeat ($urandom_range(0, 19)) p = p * 10;
                return p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 64'd0;
                    1: return {64{1'b1}};
                    2: return {1'b1, 63'd0};
                    default: return {1'b0, {63{1'b1}}};
                endcase
            end
            3: return 64'd0 - 64'($urandom_range(1, 1000));
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    function automatic void queue_request(input logic [63:0] value, input logic [1:0] mode,
                                          input bit wait_drain);
        queued_req_t q;
        q.req.value  = value;
        q.req.mode   = mode;
        q.wait_drain = wait_drain;
        request_queue.push_back(q);
    endfunction

    // Request driver: presents queued requests with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_valid <= 1'b0;
            arg       <= '0;
            send_gap   = 0;
        end
        else
        begin
            if (arg_valid && arg_ready)
            begin
                predict_text(arg);
                requests_taken++;
            end
            if (!arg_valid || arg_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    arg_valid <= 1'b0;
                end
                else if (request_queue.size() == 0)
                begin
                    arg_valid <= 1'b0;
                end
                else if (request_queue[0].wait_drain && pending_chars.size() != 0)
                begin
                    // Hold off until the converter has delivered all text so far.
                    arg_valid <= 1'b0;
                end
                else
                begin
                    arg       <= request_queue[0].req;
                    arg_valid <= 1'b1;
                    request_queue.pop_front();
                    if (request_queue.size() >= CALM_TAIL && (requests_taken / 40) % 3 != 0
                        && $urandom_range(0, 3) == 0)
                    begin
                        send_gap = $urandom_range(1, 14);
                    end
                end
            end
        end
    end

    // Text monitor: checks each character against the oldest expected one and stalls
    // the converter in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_ready <= 1'b0;
            stall_left  = 0;
        end
        else
        begin
            if (text_valid && text_ready)
            begin
                chars_seen++;
                if (pending_chars.size() == 0)
                begin
                    $display("%0t: unexpected character expected none actual %h last %b",
                             $time, text.character, text.last);
                    error_count++;
                end
                else
                begin
                    if (text.character !== pending_chars[0].character)
                    begin
                        $display("%0t: character mismatch expected %h actual %h",
                                 $time, pending_chars[0].character, text.character);
                        error_count++;
                    end
                    if (text.last !== pending_chars[0].last)
                    begin
                        $display("%0t: last flag mismatch expected %b actual %b",
                                 $time, pending_chars[0].last, text.last);
                        error_count++;
                    end
                    pending_chars.pop_front();
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                text_ready <= 1'b0;
            end
            else if (request_queue.size() >= CALM_TAIL && (chars_seen / 150) % 3 != 0
                     && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                text_ready <= 1'b0;
            end
            else
            begin
                text_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a long stretch with no request and no character taken means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((arg_valid && arg_ready) || (text_valid && text_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_integer_to_ascii_converter: errors");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int i;
        // Zero in every mode, including the undefined mode three.
        queue_request(64'd0, MODE_UNSIGNED, 1'b0);
        queue_request(64'd0, MODE_SIGNED, 1'b0);
        queue_request(64'd0, MODE_HEX, 1'b0);
        queue_request(64'd0, MODE_HEX_ALT, 1'b0);
        // All ones: longest unsigned text, minus one, and full hex.
        queue_request({64{1'b1}}, MODE_UNSIGNED, 1'b0);
        queue_request({64{1'b1}}, MODE_SIGNED, 1'b0);
        queue_request({64{1'b1}}, MODE_HEX, 1'b0);
        queue_request({64{1'b1}}, MODE_HEX_ALT, 1'b0);
        // Most negative value and its neighbor.
        queue_request({1'b1, 63'd0}, MODE_SIGNED, 1'b0);
        queue_request({1'b1, 63'd0}, MODE_UNSIGNED, 1'b0);
        queue_request({1'b1, 63'd0}, MODE_HEX, 1'b0);
        queue_request({1'b0, {63{1'b1}}}, MODE_SIGNED, 1'b0);
        queue_request({1'b0, {63{1'b1}}}, MODE_UNSIGNED, 1'b0);
        // Digit-count boundaries.
        queue_request(64'd1, MODE_SIGNED, 1'b0);
        queue_request(64'd9, MODE_UNSIGNED, 1'b0);
        queue_request(64'd10, MODE_UNSIGNED, 1'b0);
        queue_request(64'd15, MODE_HEX, 1'b0);
        queue_request(64'd16, MODE_HEX, 1'b0);
        queue_request(64'd999999, MODE_UNSIGNED, 1'b0);
        queue_request(64'd10000000000000000000, MODE_UNSIGNED, 1'b0);
        queue_request(64'd9999999999999999999, MODE_SIGNED, 1'b0);
        queue_request(64'hFEDC_BA98_7654_3210, MODE_HEX, 1'b0);
        queue_request(64'h0123_4567_89AB_CDEF, MODE_HEX_ALT, 1'b0);
        queue_request(64'hA5A5_5A5A_A5A5_5A5A, MODE_HEX_ALT, 1'b0);
        // Random part; the first request and a few others wait for the text to drain.
        for (i = 0; i < RANDOM_COUNT; i++)
        begin
            queue_request(random_value(), 2'($urandom_range(0, 3)),
                          i == 0 || $urandom_range(0, 59) == 0);
        end
        total_requests = request_queue.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_taken != total_requests || pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("tb_integer_to_ascii_converter: clean");
        end
        else
        begin
            $display("tb_integer_to_ascii_converter: errors");
        end
        $finish;
    end

endmodule
